>>> hdl/ilid_pkg.sv
// Shared types and constants for the indexed list block.
`default_nettype none

package ilid_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int DATA_W       = 32;
    localparam int INDEX_W      = 10;
    localparam int GROUP_SIZE   = 16;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_INSERT = 2'd1,
        OP_APPEND = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GATHER,
        S_SEND
    } state_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic do_ins;
        logic do_del;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> hdl/ilid_cell.sv
// One list position: holds a value and shifts with its neighbors.
`default_nettype none

module ilid_cell #(
    parameter int CMP_W = 9,
    parameter int INDEX = 0
) (
    input  wire logic                           aclk,
    input  wire ilid_pkg::cell_ctl_t            ctl,
    input  wire logic [CMP_W-1:0]               pos,
    input  wire logic [ilid_pkg::DATA_W-1:0]    ins_value,
    input  wire logic [ilid_pkg::DATA_W-1:0]    left_value,
    input  wire logic [ilid_pkg::DATA_W-1:0]    right_value,
    output logic      [ilid_pkg::DATA_W-1:0]    value_out,
    output logic      [ilid_pkg::DATA_W-1:0]    match_value
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic [ilid_pkg::DATA_W-1:0] value_reg;
    logic [ilid_pkg::DATA_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        if (ctl.do_ins) begin
            if (MY_IDX > pos) begin
                value_next = left_value;
            end else if (MY_IDX == pos) begin
                value_next = ins_value;
            end
        end else if (ctl.do_del) begin
            if (MY_IDX >= pos) begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value_out   = value_reg;
    // Only the addressed cell puts its value on the OR tree.
    assign match_value = (MY_IDX == pos) ? value_reg : '0;

endmodule

`default_nettype wire

>>> hdl/ilid_gather.sv
// Registered two-level OR tree that collects the addressed cell's value.
`default_nettype none

module ilid_gather #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           load,
    input  wire logic [ilid_pkg::DATA_W-1:0]    match_values [CAPACITY],
    output logic      [ilid_pkg::DATA_W-1:0]    read_value
);

    localparam int GROUP = ilid_pkg::GROUP_SIZE;
    localparam int NGRP  = (CAPACITY + GROUP - 1) / GROUP;

    logic [ilid_pkg::DATA_W-1:0] grp_reg  [NGRP];
    logic [ilid_pkg::DATA_W-1:0] grp_next [NGRP];

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        always_comb begin
            grp_next[g] = '0;
            for (int j = 0; j < GROUP; j++) begin
                if (g * GROUP + j < CAPACITY) begin
                    grp_next[g] = grp_next[g] | match_values[g * GROUP + j];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (load) begin
                grp_reg[g] <= grp_next[g];
            end
        end
    end

    always_comb begin
        read_value = '0;
        for (int g = 0; g < NGRP; g++) begin
            read_value = read_value | grp_reg[g];
        end
    end

endmodule

`default_nettype wire

>>> hdl/indexed_list_insert_delete.sv
// Indexed list: a chain of value cells that shift together on insert and delete.
// The first OR level of the read path registers at the accepting edge; the second
// feeds the output register. A new item is taken only while idle, once the result
// of the last item has left the gather step; the output register lets the next
// item in while a result still waits.
// Reset clears the element count and the handshake state; cell contents stay undefined.
`default_nettype none

module indexed_list_insert_delete #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [1:0]                         s_op,
    input  wire logic signed [ilid_pkg::INDEX_W-1:0] s_index,
    input  wire logic signed [ilid_pkg::DATA_W-1:0] s_value,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [ilid_pkg::DATA_W-1:0]      m_read_value,
    output logic [1:0]                              m_status,
    output logic [CNT_W-1:0]                        m_length
);

    localparam int POS_W = ilid_pkg::INDEX_W - 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    ilid_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    ilid_pkg::status_t status_reg;
    logic              rd_ok_reg;
    logic [ilid_pkg::DATA_W-1:0] pend_value_reg;

    logic                        m_valid_reg;
    logic [ilid_pkg::DATA_W-1:0] m_value_reg;
    ilid_pkg::status_t           m_status_reg;
    logic [CNT_W-1:0]            m_length_reg;

    logic                accept;
    logic                out_free;
    logic                out_load;
    logic                pend_load;
    ilid_pkg::cell_ctl_t ctl, cell_ctl;
    ilid_pkg::status_t   status;
    logic                rd_ok;
    logic [CMP_W-1:0]    pos_ext, cnt_ext, cell_pos;
    logic [ilid_pkg::DATA_W-1:0] gather_value, result_value, out_value;

    logic [ilid_pkg::DATA_W-1:0] cell_vals    [CAPACITY];
    logic [ilid_pkg::DATA_W-1:0] match_values [CAPACITY];

    assign s_ready  = aresetn && (state_reg == ilid_pkg::S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Request decode against the current count.
    always_comb begin
        pos_ext  = s_index[ilid_pkg::INDEX_W-1] ? '0 : CMP_W'(s_index[POS_W-1:0]);
        cnt_ext  = CMP_W'(cnt_reg);
        cell_pos = pos_ext;
        ctl      = '0;
        status   = ilid_pkg::STAT_DONE;
        rd_ok    = 1'b0;
        case (ilid_pkg::op_t'(s_op))
            ilid_pkg::OP_READ: begin
                if (s_index[ilid_pkg::INDEX_W-1] || pos_ext >= cnt_ext) begin
                    status = ilid_pkg::STAT_RANGE;
                end else begin
                    rd_ok = 1'b1;
                end
            end
            ilid_pkg::OP_INSERT: begin
                // range check comes before the full check
                if (pos_ext > cnt_ext) begin
                    status = ilid_pkg::STAT_RANGE;
                end else if (cnt_reg >= CAP_CNT) begin
                    status = ilid_pkg::STAT_FULL;
                end else begin
                    ctl.do_ins = 1'b1;
                end
            end
            ilid_pkg::OP_APPEND: begin
                cell_pos = cnt_ext;
                if (cnt_reg >= CAP_CNT) begin
                    status = ilid_pkg::STAT_FULL;
                end else begin
                    ctl.do_ins = 1'b1;
                end
            end
            ilid_pkg::OP_DELETE: begin
                if (pos_ext >= cnt_ext) begin
                    status = ilid_pkg::STAT_RANGE;
                end else begin
                    ctl.do_del = 1'b1;
                end
            end
            default: begin
                status = ilid_pkg::STAT_RANGE;
            end
        endcase
        cell_ctl.do_ins = ctl.do_ins && accept;
        cell_ctl.do_del = ctl.do_del && accept;
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cell_ctl.do_ins) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (cell_ctl.do_del) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [ilid_pkg::DATA_W-1:0] left_value;
        logic [ilid_pkg::DATA_W-1:0] right_value;

        if (k == 0) begin : g_head
            assign left_value = '0;
        end else begin : g_body
            assign left_value = cell_vals[k-1];
        end

        if (k == CAPACITY - 1) begin : g_tail
            assign right_value = cell_vals[k];
        end else begin : g_inner
            assign right_value = cell_vals[k+1];
        end

        ilid_cell #(
            .CMP_W (CMP_W),
            .INDEX (k)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (cell_ctl),
            .pos         (cell_pos),
            .ins_value   (s_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value_out   (cell_vals[k]),
            .match_value (match_values[k])
        );
    end

    ilid_gather #(
        .CAPACITY (CAPACITY)
    ) u_gather (
        .aclk         (aclk),
        .load         (accept),
        .match_values (match_values),
        .read_value   (gather_value)
    );

    assign result_value = rd_ok_reg ? gather_value : '1;
    assign out_value    = (state_reg == ilid_pkg::S_SEND) ? pend_value_reg : result_value;

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        pend_load  = 1'b0;
        case (state_reg)
            ilid_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = ilid_pkg::S_GATHER;
                end
            end
            ilid_pkg::S_GATHER: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ilid_pkg::S_IDLE;
                end else begin
                    pend_load  = 1'b1;
                    state_next = ilid_pkg::S_SEND;
                end
            end
            ilid_pkg::S_SEND: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ilid_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ilid_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ilid_pkg::S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status;
            rd_ok_reg  <= rd_ok;
        end
        if (pend_load) begin
            pend_value_reg <= result_value;
        end
        if (out_load) begin
            m_value_reg  <= out_value;
            m_status_reg <= status_reg;
            m_length_reg <= cnt_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_value_reg;
    assign m_status     = m_status_reg;
    assign m_length     = m_length_reg;

endmodule

`default_nettype wire

>>> tb/indexed_list_insert_delete_test.sv
// Self-checking testbench for the indexed list block: directed table, then random traffic.
`default_nettype none

module indexed_list_insert_delete_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = ilid_pkg::CAPACITY_DEF;
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam logic [ilid_pkg::DATA_W-1:0] NO_VALUE = '1;
    localparam logic signed [ilid_pkg::INDEX_W-1:0] IDX_MIN = 10'b10_0000_0000;
    localparam logic signed [ilid_pkg::INDEX_W-1:0] IDX_MAX = 10'sd511;
    localparam int TOTAL_ITEMS = 1850;

    typedef struct packed {
        logic [ilid_pkg::DATA_W-1:0] read_value;
        ilid_pkg::status_t           status;
        logic [LEN_W-1:0]            length;
    } list_result_t;

    // One stimulus row; typed rows carry the result that is expected for them.
    typedef struct packed {
        ilid_pkg::op_t                       op;
        logic signed [ilid_pkg::INDEX_W-1:0] idx;
        logic [ilid_pkg::DATA_W-1:0]         val;
        logic                                typed;
        logic [ilid_pkg::DATA_W-1:0]         rv;
        ilid_pkg::status_t                   st;
        logic [LEN_W-1:0]                    len;
    } list_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_op = '0;
    logic signed [ilid_pkg::INDEX_W-1:0] s_index = '0;
    logic signed [ilid_pkg::DATA_W-1:0] s_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [ilid_pkg::DATA_W-1:0] m_read_value;
    logic [1:0] m_status;
    logic [LEN_W-1:0] m_length;

    list_row_t offered_row = '0;

    logic [ilid_pkg::DATA_W-1:0] shadow_list[$];
    list_result_t pending_results[$];
    int mismatch_count = 0;
    int items_sent = 0;
    bit sender_burst = 1'b0;

    list_row_t directed_rows [24] = '{
        '{ilid_pkg::OP_READ, 10'sd0, 32'd0, 1'b1, NO_VALUE, ilid_pkg::STAT_RANGE, 9'd0},
        '{ilid_pkg::OP_DELETE, 10'sd0, 32'd0, 1'b1, NO_VALUE, ilid_pkg::STAT_RANGE, 9'd0},
        '{ilid_pkg::OP_INSERT, 10'sd1, 32'd5, 1'b1, NO_VALUE, ilid_pkg::STAT_RANGE, 9'd0},
        '{ilid_pkg::OP_APPEND, 10'sd0, 32'h8000_0000, 1'b1, NO_VALUE, ilid_pkg::STAT_DONE, 9'd1},
        '{ilid_pkg::OP_INSERT, IDX_MIN, 32'h7fff_ffff, 1'b1, NO_VALUE, ilid_pkg::STAT_DONE, 9'd2},
        '{ilid_pkg::OP_READ, 10'sd0, 32'd0, 1'b1, 32'h7fff_ffff, ilid_pkg::STAT_DONE, 9'd2},
        '{ilid_pkg::OP_READ, 10'sd1, 32'd0, 1'b1, 32'h8000_0000, ilid_pkg::STAT_DONE, 9'd2},
        '{ilid_pkg::OP_READ, -10'sd1, 32'd0, 1'b1, NO_VALUE, ilid_pkg::STAT_RANGE, 9'd2},
        '{ilid_pkg::OP_READ, 10'sd2, 32'd0, 1'b1, NO_VALUE, ilid_pkg::STAT_RANGE, 9'd2},
        '{ilid_pkg::OP_READ, IDX_MAX, 32'd0, 1'b1, NO_VALUE, ilid_pkg::STAT_RANGE, 9'd2},
        '{ilid_pkg::OP_INSERT, 10'sd2, 32'd0, 1'b0, '0, ilid_pkg::STAT_DONE, 9'd0},
        '{ilid_pkg::OP_INSERT, 10'sd1, 32'hffff_ffff, 1'b0, '0, ilid_pkg::STAT_DONE, 9'd0},
        '{ilid_pkg::OP_READ, 10'sd1, 32'd0, 1'b0, '0, ilid_pkg::STAT_DONE, 9'd0},
        '{ilid_pkg::OP_INSERT, IDX_MAX, 32'd1, 1'b1, NO_VALUE, ilid_pkg::STAT_RANGE, 9'd4},
        '{ilid_pkg::OP_INSERT, 10'sd5, 32'd1, 1'b1, NO_VALUE, ilid_pkg::STAT_RANGE, 9'd4},
        '{ilid_pkg::OP_APPEND, IDX_MIN, 32'h1234_5678, 1'b0, '0, ilid_pkg::STAT_DONE, 9'd0},
        '{ilid_pkg::OP_DELETE, IDX_MIN, 32'hffff_ffff, 1'b0, '0, ilid_pkg::STAT_DONE, 9'd0},
        '{ilid_pkg::OP_DELETE, IDX_MAX, 32'd0, 1'b1, NO_VALUE, ilid_pkg::STAT_RANGE, 9'd4},
        '{ilid_pkg::OP_DELETE, 10'sd4, 32'd0, 1'b1, NO_VALUE, ilid_pkg::STAT_RANGE, 9'd4},
        '{ilid_pkg::OP_DELETE, 10'sd3, 32'd0, 1'b0, '0, ilid_pkg::STAT_DONE, 9'd0},
        '{ilid_pkg::OP_READ, 10'sd2, 32'd0, 1'b0, '0, ilid_pkg::STAT_DONE, 9'd0},
        '{ilid_pkg::OP_READ, IDX_MIN, 32'd0, 1'b1, NO_VALUE, ilid_pkg::STAT_RANGE, 9'd3},
        '{ilid_pkg::OP_DELETE, 10'sd1, 32'd0, 1'b0, '0, ilid_pkg::STAT_DONE, 9'd0},
        '{ilid_pkg::OP_READ, 10'sd1, 32'd0, 1'b0, '0, ilid_pkg::STAT_DONE, 9'd0}
    };

    indexed_list_insert_delete #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_index(s_index),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_read_value(m_read_value),
        .m_status(m_status),
        .m_length(m_length)
    );

    always #5ns aclk = ~aclk;

    // Applies one request to the shadow list and returns the result it yields.
    function automatic list_result_t apply_list_op(
        input ilid_pkg::op_t op,
        input logic signed [ilid_pkg::INDEX_W-1:0] idx,
        input logic [ilid_pkg::DATA_W-1:0] val);
        list_result_t res;
        int count;
        int pos;
        count = shadow_list.size();
        pos = (idx < 0) ? 0 : int'(idx);
        res.read_value = NO_VALUE;
        res.status = ilid_pkg::STAT_DONE;
        case (op)
            ilid_pkg::OP_READ: begin
                if (idx < 0 || pos >= count) begin
                    res.status = ilid_pkg::STAT_RANGE;
                end else begin
                    res.read_value = shadow_list[pos];
                end
            end
            ilid_pkg::OP_INSERT, ilid_pkg::OP_APPEND: begin
                if (op == ilid_pkg::OP_APPEND) begin
                    pos = count;
                end
                // range is checked ahead of the full check
                if (pos > count) begin
                    res.status = ilid_pkg::STAT_RANGE;
                end else if (count >= CAPACITY) begin
                    res.status = ilid_pkg::STAT_FULL;
                end else begin
                    shadow_list.insert(pos, val);
                end
            end
            default: begin
                if (pos >= count) begin
                    res.status = ilid_pkg::STAT_RANGE;
                end else begin
                    shadow_list.delete(pos);
                end
            end
        endcase
        res.length = LEN_W'(shadow_list.size());
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    function automatic logic signed [ilid_pkg::INDEX_W-1:0] pick_index();
        int count;
        int r;
        int v;
        count = shadow_list.size();
        r = $urandom_range(0, 99);
        if (r < 65) begin
            v = $urandom_range(0, count);
        end else if (r < 80) begin
            v = count - 1 + $urandom_range(0, 2);
        end else if (r < 90) begin
            v = -$urandom_range(1, 512);
        end else begin
            v = $urandom;
        end
        return v[ilid_pkg::INDEX_W-1:0];
    endfunction

    function automatic logic [ilid_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic offer_item(input list_row_t row);
        int gap;
        if (items_sent % 40 == 0) begin
            sender_burst = ($urandom_range(0, 3) == 0);
        end
        gap = sender_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= row.op;
        s_index <= row.idx;
        s_value <= row.val;
        offered_row <= row;
        do @(posedge aclk); while (!(s_valid && s_ready));
        items_sent++;
    endtask

    task automatic send_random(input ilid_pkg::op_t op);
        list_row_t row;
        row = '0;
        row.op = op;
        row.idx = pick_index();
        row.val = pick_value();
        offer_item(row);
    endtask

    // Stop offering and let every outstanding result come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    always @(posedge aclk) begin : list_monitor
        list_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = apply_list_op(ilid_pkg::op_t'(s_op), s_index, s_value);
                if (offered_row.typed) begin
                    want.read_value = offered_row.rv;
                    want.status = offered_row.st;
                    want.length = offered_row.len;
                end
                pending_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = pending_results.pop_front();
                    if (m_read_value !== want.read_value) begin
                        report_mismatch($sformatf("read_value %h, want %h",
                                                  m_read_value, want.read_value));
                    end
                    if (m_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_status, want.status));
                    end
                    if (m_length !== want.length) begin
                        report_mismatch($sformatf("length %0d, want %0d",
                                                  m_length, want.length));
                    end
                end
            end
        end
    end

    initial begin : result_sink
        int stall;
        int sink_count;
        bit sink_burst;
        sink_count = 0;
        sink_burst = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (sink_count % 40 == 0) begin
                sink_burst = ($urandom_range(0, 3) == 0);
            end
            // long hold-off: the block backs up and stalls its input
            if (sink_count == 300 || sink_count == 1500) begin
                stall = 100;
            end else begin
                stall = sink_burst ? 0 : $urandom_range(0, 4);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            sink_count++;
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int r;
        ilid_pkg::op_t op;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            offer_item(directed_rows[i]);
        end

        // mixed traffic, list grows slowly
        while (items_sent < 625) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                op = ilid_pkg::OP_READ;
            end else if (r < 60) begin
                op = ilid_pkg::OP_INSERT;
            end else if (r < 75) begin
                op = ilid_pkg::OP_APPEND;
            end else begin
                op = ilid_pkg::OP_DELETE;
            end
            send_random(op);
        end
        drain_results();

        // fill up to capacity with reads mixed in
        while (shadow_list.size() < CAPACITY) begin
            r = $urandom_range(0, 3);
            if (r == 0) begin
                op = ilid_pkg::OP_READ;
            end else if (r == 1) begin
                op = ilid_pkg::OP_APPEND;
            end else begin
                op = ilid_pkg::OP_INSERT;
            end
            send_random(op);
        end
        // inserts and appends, mostly dropped, mixed with reads and deletes on a full list
        repeat (80) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                op = ilid_pkg::OP_INSERT;
            end else if (r < 50) begin
                op = ilid_pkg::OP_APPEND;
            end else if (r < 92) begin
                op = ilid_pkg::OP_READ;
            end else begin
                op = ilid_pkg::OP_DELETE;
            end
            send_random(op);
        end
        // empty it again
        while (shadow_list.size() > 0) begin
            if ($urandom_range(0, 3) == 0) begin
                op = ilid_pkg::OP_READ;
            end else begin
                op = ilid_pkg::OP_DELETE;
            end
            send_random(op);
        end
        drain_results();

        while (items_sent < TOTAL_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                op = ilid_pkg::OP_READ;
            end else if (r < 55) begin
                op = ilid_pkg::OP_INSERT;
            end else if (r < 70) begin
                op = ilid_pkg::OP_APPEND;
            end else begin
                op = ilid_pkg::OP_DELETE;
            end
            send_random(op);
        end
        drain_results();
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
